@@ sv/tki_pkg.sv @@
// shared constants and types for the top-k score table
`timescale 1ns / 1ps

package tki_pkg;

   // table geometry
   localparam int MAX_ENTRIES      = 10;
   localparam int NUM_MODES        = 2;
   localparam int NUM_DIFFICULTIES = 3;
   localparam int NUM_LISTS        = NUM_MODES * NUM_DIFFICULTIES;
   localparam int DEPTH            = NUM_LISTS * MAX_ENTRIES;

   // derived widths
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

   // fixed field widths
   localparam int SCORE_W  = 24;
   localparam int LENGTH_W = 16;
   localparam int DATE_W   = 21;
   localparam int INDEX_W  = 4;
   localparam int RANK_W   = 4;
   localparam int COUNT_W  = 4;

   // stream word widths
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 5;
   localparam int RSP_DATA_W = 96;

   // full-list count in counter width
   localparam logic [CNT_W-1:0] K_CNT = CNT_W'(MAX_ENTRIES);

   // request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_READ   = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // one stored entry
   typedef struct packed {
      logic [SCORE_W-1:0]  score;
      logic [LENGTH_W-1:0] length;
      logic [DATE_W-1:0]   date;
   } entry_type;

endpackage

@@ sv/top_k_table_insert_top.sv @@
// bank of sorted top-k score lists with insert, read and clear
`timescale 1ns / 1ps

// Holds NUM_MODES x NUM_DIFFICULTIES lists of up to MAX_ENTRIES entries each, sorted by
// descending score, in one single-port-write / single-port-read entry memory. An insert
// walks its list from the tail toward the head, one entry per cycle, moving each lower
// score down one place until it meets a score equal or higher, then writes the new
// entry there; when the new entry tops the list, a further state writes it at the head.
// Inserts, reads and unused request kinds then fetch the head entry for the best score
// if the list is not empty, and the output register is loaded last. A read of a stored
// entry first captures that entry; a read past the count or an unused request kind goes
// straight to the best-score fetch, and a clear or a request for a list that does not
// exist goes straight to the output register. One request is handled at a time;
// req_tready is high only while the sequencer is idle. A finished result waits in the
// output register without holding up the next request, but the next result cannot
// leave the sequencer until that word has been taken. Stored entries need no clearing
// after reset: the list counts start at zero and nothing at or beyond a count is ever
// read.
module top_k_table_insert_top (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: new_score[23:0], new_length[39:24], new_date[60:40], read_index[64:61]
   input  logic [tki_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: req_type[1:0], mode[2], difficulty[4:3]
   input  logic [tki_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: placed[0], rank[4:1], best_score[28:5], list_count[32:29], entry_valid[33],
   //        entry_score[57:34], entry_length[73:58], entry_date[94:74]
   output logic [tki_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_PUT,
      ST_READ,
      ST_BEST,
      ST_BEST_WAIT,
      ST_DONE
   } state_type;

   // unpacked request fields
   logic [1:0]                      req_type;
   logic                            req_mode;
   logic [1:0]                      req_difficulty;
   logic [tki_pkg::SCORE_W-1:0]     req_score;
   logic [tki_pkg::LENGTH_W-1:0]    req_length;
   logic [tki_pkg::DATE_W-1:0]      req_date;
   logic [tki_pkg::INDEX_W-1:0]     req_index;

   // sequencer and working registers
   state_type                       state_ff, state_in;
   logic                            sel_ok_ff, sel_ok_in;
   logic [tki_pkg::LIST_W-1:0]      list_ff, list_in;
   logic [tki_pkg::ADDR_W-1:0]      base_ff, base_in;
   logic [tki_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [tki_pkg::CNT_W-1:0]       j_ff, j_in;
   tki_pkg::entry_type              new_ff, new_in;

   // result being built
   logic                            placed_ff, placed_in;
   logic [tki_pkg::CNT_W-1:0]       rank_ff, rank_in;
   logic [tki_pkg::CNT_W-1:0]       new_cnt_ff, new_cnt_in;
   logic [tki_pkg::SCORE_W-1:0]     best_ff, best_in;
   logic                            ev_ff, ev_in;
   tki_pkg::entry_type              ent_ff, ent_in;

   // output word
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tki_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // per-list counts
   logic [tki_pkg::CNT_W-1:0]       list_cnt_ff [tki_pkg::NUM_LISTS];
   logic                            cnt_we;

   // entry memory
   tki_pkg::entry_type              mem [tki_pkg::DEPTH];
   tki_pkg::entry_type              rd_ff;
   logic                            mem_we;
   logic [tki_pkg::ADDR_W-1:0]      mem_waddr;
   tki_pkg::entry_type              mem_wdata;
   logic [tki_pkg::ADDR_W-1:0]      mem_raddr;

   // request decode
   logic                            sel_ok;
   logic [tki_pkg::LIST_W-1:0]      sel_list;
   logic [tki_pkg::ADDR_W-1:0]      sel_base;
   logic [tki_pkg::CNT_W-1:0]       sel_cnt;
   logic [tki_pkg::CNT_W-1:0]       j_next;
   logic [tki_pkg::CNT_W-1:0]       cnt_plus;

   assign req_type       = req_tuser[1:0];
   assign req_mode       = req_tuser[2];
   assign req_difficulty = req_tuser[4:3];
   assign req_score      = req_tdata[23:0];
   assign req_length     = req_tdata[39:24];
   assign req_date       = req_tdata[60:40];
   assign req_index      = req_tdata[64:61];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // list selection for the incoming word
   assign sel_ok   = (int'(req_mode) < tki_pkg::NUM_MODES) &&
                     (int'(req_difficulty) < tki_pkg::NUM_DIFFICULTIES);
   assign sel_list = tki_pkg::LIST_W'(int'(req_mode) * tki_pkg::NUM_DIFFICULTIES +
                                      int'(req_difficulty));
   assign sel_base = tki_pkg::ADDR_W'(int'(sel_list) * tki_pkg::MAX_ENTRIES);
   assign sel_cnt  = sel_ok ? list_cnt_ff[sel_list] : '0;

   assign j_next   = tki_pkg::CNT_W'(j_ff + 1'b1);
   assign cnt_plus = (cnt_ff < tki_pkg::K_CNT) ? tki_pkg::CNT_W'(cnt_ff + 1'b1) : cnt_ff;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      sel_ok_in    = sel_ok_ff;
      list_in      = list_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      j_in         = j_ff;
      new_in       = new_ff;
      placed_in    = placed_ff;
      rank_in      = rank_ff;
      new_cnt_in   = new_cnt_ff;
      best_in      = best_ff;
      ev_in        = ev_ff;
      ent_in       = ent_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cnt_we       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = base_ff;
      mem_wdata    = new_ff;
      mem_raddr    = base_ff;

      // output word taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sel_ok_in  = sel_ok;
               list_in    = sel_list;
               base_in    = sel_base;
               cnt_in     = sel_cnt;
               new_in     = '{score: req_score, length: req_length, date: req_date};
               placed_in  = 1'b0;
               rank_in    = '0;
               new_cnt_in = sel_cnt;
               best_in    = '0;
               ev_in      = 1'b0;
               ent_in     = '0;
               if (!sel_ok) begin
                  state_in = ST_DONE;
               end else begin
                  case (req_type)
                     tki_pkg::REQ_INSERT: begin
                        if (sel_cnt == '0) begin
                           // empty list: new word lands at the head
                           mem_we     = 1'b1;
                           mem_waddr  = sel_base;
                           mem_wdata  = '{score: req_score, length: req_length,
                                          date: req_date};
                           placed_in  = 1'b1;
                           new_cnt_in = tki_pkg::CNT_W'(1);
                           state_in   = ST_BEST;
                        end else begin
                           // start the walk at the tail
                           j_in      = tki_pkg::CNT_W'(sel_cnt - 1'b1);
                           mem_raddr = tki_pkg::ADDR_W'(sel_base +
                                          tki_pkg::ADDR_W'(sel_cnt - 1'b1));
                           state_in  = ST_WALK;
                        end
                     end
                     tki_pkg::REQ_READ: begin
                        if (tki_pkg::CNT_W'(req_index) < sel_cnt &&
                            int'(req_index) < tki_pkg::MAX_ENTRIES) begin
                           mem_raddr = tki_pkg::ADDR_W'(sel_base +
                                          tki_pkg::ADDR_W'(req_index));
                           state_in  = ST_READ;
                        end else begin
                           state_in = ST_BEST;
                        end
                     end
                     tki_pkg::REQ_CLEAR: begin
                        new_cnt_in = '0;
                        state_in   = ST_DONE;
                     end
                     default: begin
                        state_in = ST_BEST;
                     end
                  endcase
               end
            end
         end

         ST_WALK: begin
            if (rd_ff.score >= new_ff.score) begin
               // stop: new word goes just below this one
               if (j_next < tki_pkg::K_CNT) begin
                  mem_we     = 1'b1;
                  mem_waddr  = tki_pkg::ADDR_W'(base_ff + tki_pkg::ADDR_W'(j_next));
                  placed_in  = 1'b1;
                  rank_in    = j_next;
                  new_cnt_in = cnt_plus;
               end
               state_in = ST_BEST;
            end else begin
               // move the lower score down one place, tail drops off
               if (j_next < tki_pkg::K_CNT) begin
                  mem_we    = 1'b1;
                  mem_waddr = tki_pkg::ADDR_W'(base_ff + tki_pkg::ADDR_W'(j_next));
                  mem_wdata = rd_ff;
               end
               if (j_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  j_in      = tki_pkg::CNT_W'(j_ff - 1'b1);
                  mem_raddr = tki_pkg::ADDR_W'(base_ff +
                                 tki_pkg::ADDR_W'(j_ff - 1'b1));
               end
            end
         end

         ST_PUT: begin
            // new word takes the head
            mem_we     = 1'b1;
            mem_waddr  = base_ff;
            placed_in  = 1'b1;
            rank_in    = '0;
            new_cnt_in = cnt_plus;
            state_in   = ST_BEST;
         end

         ST_READ: begin
            ev_in    = 1'b1;
            ent_in   = rd_ff;
            state_in = ST_BEST;
         end

         ST_BEST: begin
            if (new_cnt_ff != '0) begin
               mem_raddr = base_ff;
               state_in  = ST_BEST_WAIT;
            end else begin
               best_in  = '0;
               state_in = ST_DONE;
            end
         end

         ST_BEST_WAIT: begin
            best_in  = rd_ff.score;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cnt_we       = sel_ok_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, ent_ff.date, ent_ff.length, ent_ff.score, ev_ff,
                               tki_pkg::COUNT_W'(new_cnt_ff), best_ff,
                               tki_pkg::RANK_W'(rank_ff), placed_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, counts and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < tki_pkg::NUM_LISTS; i++) begin
            list_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            list_cnt_ff[list_ff] <= new_cnt_ff;
         end
      end
      sel_ok_ff   <= sel_ok_in;
      list_ff     <= list_in;
      base_ff     <= base_in;
      cnt_ff      <= cnt_in;
      j_ff        <= j_in;
      new_ff      <= new_in;
      placed_ff   <= placed_in;
      rank_ff     <= rank_in;
      new_cnt_ff  <= new_cnt_in;
      best_ff     <= best_in;
      ev_ff       <= ev_in;
      ent_ff      <= ent_in;
      rsp_data_ff <= rsp_data_in;
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

endmodule

@@ sv/tki_check.sv @@
// port checks for the top-k score table, bound to the top level
`timescale 1ns / 1ps

module tki_check (
   input logic                            clock,
   input logic                            reset,
   input logic [tki_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [tki_pkg::REQ_USER_W-1:0]  req_tuser,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [tki_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // a stalled result word keeps its bits
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // the block is busy right after taking a request word
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in flight");

   // list count never exceeds the list size
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> int'(rsp_tdata[32:29]) <= tki_pkg::MAX_ENTRIES)
      else $error("list count above list size");

   // a word that was not placed reports rank zero
   a_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[4:1] == '0)
      else $error("nonzero rank without placement");

endmodule

bind top_k_table_insert_top tki_check u_tki_check (.*);

@@ tb/sv/tb_top_k_table_insert_top.sv @@
// self-checking testbench for the top-k score table block
`timescale 1ns / 1ps

module tb_top_k_table_insert_top;

   // request kind and difficulty code without a name in the package
   localparam logic [1:0] REQ_NOP        = 2'd3;
   localparam logic [1:0] BAD_DIFFICULTY = 2'd3;

   // one request word, unpacked
   typedef struct {
      logic [1:0]                   kind;
      logic                         mode;
      logic [1:0]                   difficulty;
      logic [tki_pkg::SCORE_W-1:0]  score;
      logic [tki_pkg::LENGTH_W-1:0] length;
      logic [tki_pkg::DATE_W-1:0]   date;
      logic [tki_pkg::INDEX_W-1:0]  index;
   } score_req_type;

   // one response word, unpacked
   typedef struct {
      logic                         placed;
      logic [tki_pkg::RANK_W-1:0]   rank;
      logic [tki_pkg::SCORE_W-1:0]  best_score;
      logic [tki_pkg::COUNT_W-1:0]  list_count;
      logic                         entry_valid;
      logic [tki_pkg::SCORE_W-1:0]  entry_score;
      logic [tki_pkg::LENGTH_W-1:0] entry_length;
      logic [tki_pkg::DATE_W-1:0]   entry_date;
   } score_rsp_type;

   // shadow copy of the score lists plus the queue of responses still owed
   class score_table_type;
      logic [tki_pkg::SCORE_W-1:0]  scores  [tki_pkg::NUM_LISTS][tki_pkg::MAX_ENTRIES];
      logic [tki_pkg::LENGTH_W-1:0] lengths [tki_pkg::NUM_LISTS][tki_pkg::MAX_ENTRIES];
      logic [tki_pkg::DATE_W-1:0]   dates   [tki_pkg::NUM_LISTS][tki_pkg::MAX_ENTRIES];
      int                           counts  [tki_pkg::NUM_LISTS];
      score_rsp_type                expected_rsp [$];
      int                           mismatches;

      function new();
         foreach (counts[l]) counts[l] = 0;
         foreach (scores[l, p]) begin
            scores[l][p]  = '0;
            lengths[l][p] = '0;
            dates[l][p]   = '0;
         end
         mismatches = 0;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      // apply one accepted request to the shadow lists and queue its response
      function void note_request(score_req_type r);
         score_rsp_type e;
         int lst, cnt, pos, last;
         e = '{default: '0};
         if (r.mode < tki_pkg::NUM_MODES && r.difficulty < tki_pkg::NUM_DIFFICULTIES) begin
            lst = r.mode * tki_pkg::NUM_DIFFICULTIES + r.difficulty;
            cnt = counts[lst];
            case (r.kind)
               tki_pkg::REQ_INSERT: begin
                  // new entry lands after every equal or higher score
                  pos = 0;
                  while (pos < cnt && scores[lst][pos] >= r.score) pos++;
                  if (pos < tki_pkg::MAX_ENTRIES) begin
                     last = (cnt < tki_pkg::MAX_ENTRIES) ? cnt : tki_pkg::MAX_ENTRIES - 1;
                     for (int i = last; i > pos; i--) begin
                        scores[lst][i]  = scores[lst][i-1];
                        lengths[lst][i] = lengths[lst][i-1];
                        dates[lst][i]   = dates[lst][i-1];
                     end
                     scores[lst][pos]  = r.score;
                     lengths[lst][pos] = r.length;
                     dates[lst][pos]   = r.date;
                     if (cnt < tki_pkg::MAX_ENTRIES) cnt++;
                     e.placed = 1'b1;
                     e.rank   = tki_pkg::RANK_W'(pos);
                  end
               end
               tki_pkg::REQ_READ: begin
                  if (r.index < cnt) begin
                     e.entry_valid  = 1'b1;
                     e.entry_score  = scores[lst][r.index];
                     e.entry_length = lengths[lst][r.index];
                     e.entry_date   = dates[lst][r.index];
                  end
               end
               tki_pkg::REQ_CLEAR: cnt = 0;
               default: ;
            endcase
            counts[lst]  = cnt;
            e.best_score = (cnt != 0) ? scores[lst][0] : '0;
            e.list_count = tki_pkg::COUNT_W'(cnt);
         end
         expected_rsp = {expected_rsp, e};
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (act !== exp) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
            mismatches++;
         end
      endfunction

      // compare one accepted response word with the oldest expectation
      function void check_response(logic [tki_pkg::RSP_DATA_W-1:0] word);
         score_rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("response 0x%0h arrived with nothing expected", word);
            mismatches++;
            return;
         end
         e = expected_rsp.pop_front();
         compare_field("placed",       32'(e.placed),       32'(word[0]));
         compare_field("rank",         32'(e.rank),         32'(word[4:1]));
         compare_field("best_score",   32'(e.best_score),   32'(word[28:5]));
         compare_field("list_count",   32'(e.list_count),   32'(word[32:29]));
         compare_field("entry_valid",  32'(e.entry_valid),  32'(word[33]));
         compare_field("entry_score",  32'(e.entry_score),  32'(word[57:34]));
         compare_field("entry_length", 32'(e.entry_length), 32'(word[73:58]));
         compare_field("entry_date",   32'(e.entry_date),   32'(word[94:74]));
      endfunction
   endclass

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic [tki_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [tki_pkg::REQ_USER_W-1:0] req_tuser  = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [tki_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   score_table_type table_model = new();

   top_k_table_insert_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side back-pressure
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // check every accepted response word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) table_model.check_response(rsp_tdata);
   end

   // present one request word and hold it until accepted; entered and left at a falling edge
   task automatic send_request(input logic [1:0] kind, input logic mode,
                               input logic [1:0] difficulty,
                               input logic [tki_pkg::SCORE_W-1:0] score,
                               input logic [tki_pkg::LENGTH_W-1:0] length,
                               input logic [tki_pkg::DATE_W-1:0] date,
                               input logic [tki_pkg::INDEX_W-1:0] index);
      score_req_type r;
      int idle;
      idle = 0;
      while ($urandom_range(99) < send_idle_pct) idle++;
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      r = '{kind, mode, difficulty, score, length, date, index};
      req_tdata  <= {7'b0, index, date, length, score};
      req_tuser  <= {difficulty, mode, kind};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      table_model.note_request(r);
      @(negedge clock);
   endtask

   // hold off the request side until every owed response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (table_model.pending() != 0);
   endtask

   // run watchdog
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // stimulus
   initial begin
      logic [1:0]                  kind;
      logic [1:0]                  difficulty;
      logic [tki_pkg::SCORE_W-1:0] score;
      logic [tki_pkg::INDEX_W-1:0] index;
      int                          pick;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty read, extremes, equal scores, reads at both ends
      send_request(tki_pkg::REQ_READ,   1'b0, 2'd0, '0, '0, '0, 4'd0);
      send_request(tki_pkg::REQ_INSERT, 1'b0, 2'd0, '1, '1, '1, 4'd0);
      send_request(tki_pkg::REQ_INSERT, 1'b0, 2'd0, '0, '0, '0, 4'd0);
      send_request(tki_pkg::REQ_INSERT, 1'b0, 2'd0, '1, 16'h1234, 21'h0ABCD, '1);
      send_request(tki_pkg::REQ_READ,   1'b0, 2'd0, '0, '0, '0, 4'd0);
      send_request(tki_pkg::REQ_READ,   1'b0, 2'd0, '0, '0, '0, 4'd1);
      send_request(tki_pkg::REQ_READ,   1'b0, 2'd0, '0, '0, '0, 4'd2);
      send_request(tki_pkg::REQ_READ,   1'b0, 2'd0, '0, '0, '0, '1);
      // unused request kind and out-of-range difficulty
      send_request(REQ_NOP,             1'b0, 2'd0, '1, '1, '1, '1);
      send_request(tki_pkg::REQ_INSERT, 1'b1, BAD_DIFFICULTY, '1, '1, '1, '1);
      // fill one list, then miss it, then push its tail out
      for (int i = 0; i < tki_pkg::MAX_ENTRIES; i++)
         send_request(tki_pkg::REQ_INSERT, 1'b1, 2'd2,
                      tki_pkg::SCORE_W'(1000 * (tki_pkg::MAX_ENTRIES - i)),
                      tki_pkg::LENGTH_W'(i), tki_pkg::DATE_W'(i), '0);
      send_request(tki_pkg::REQ_INSERT, 1'b1, 2'd2, 24'd5, '1, '1, '0);
      send_request(tki_pkg::REQ_INSERT, 1'b1, 2'd2, 24'hFFFFF0, 16'h8001, 21'h100001, '0);
      send_request(tki_pkg::REQ_READ,   1'b1, 2'd2, '0, '0, '0,
                   tki_pkg::INDEX_W'(tki_pkg::MAX_ENTRIES - 1));
      send_request(tki_pkg::REQ_CLEAR,  1'b1, 2'd2, '0, '0, '0, '0);
      send_request(tki_pkg::REQ_READ,   1'b1, 2'd2, '0, '0, '0, 4'd0);
      drain_responses();

      // random traffic over four idling phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         for (int n = 0; n < 125; n++) begin
            pick = $urandom_range(99);
            if (pick < 55)      kind = tki_pkg::REQ_INSERT;
            else if (pick < 93) kind = tki_pkg::REQ_READ;
            else if (pick < 97) kind = tki_pkg::REQ_CLEAR;
            else                kind = REQ_NOP;
            difficulty = ($urandom_range(99) < 3) ? BAD_DIFFICULTY
                       : 2'($urandom_range(tki_pkg::NUM_DIFFICULTIES - 1));
            // clustered scores give plenty of ties
            pick = $urandom_range(99);
            if (pick < 40)      score = {2'($urandom_range(3)), 22'h0};
            else if (pick < 70) score = tki_pkg::SCORE_W'($urandom_range(255));
            else                score = tki_pkg::SCORE_W'($urandom);
            index = ($urandom_range(99) < 80)
                  ? tki_pkg::INDEX_W'($urandom_range(tki_pkg::MAX_ENTRIES))
                  : tki_pkg::INDEX_W'($urandom_range(15));
            send_request(kind, 1'($urandom_range(1)), difficulty, score,
                         tki_pkg::LENGTH_W'($urandom), tki_pkg::DATE_W'($urandom), index);
         end
         drain_responses();
      end

      // let the block settle after the last response
      repeat (30) @(posedge clock);
      if (table_model.pending() != 0) begin
         $error("%0d expected responses never arrived", table_model.pending());
         table_model.mismatches++;
      end
      if (table_model.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/tki_pkg.sv
sv/top_k_table_insert_top.sv
sv/tki_check.sv
tb/sv/tb_top_k_table_insert_top.sv
